FILE: rtl/pfxdec_pkg.sv
// Package for the prefix-code bit decoder: sizes, request kinds, sequencer states,
// the result record and the code mask helper.
// No dependencies; the top level and the testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package pfxdec_pkg;

    localparam int MAX_CODE_BITS = 32;
    localparam int SYMBOL_COUNT  = 256;
    localparam int TABLE_DEPTH   = 256;
    localparam int BYTE_BITS     = 8;

    localparam int SYM_W   = 8;
    localparam int LEN_W   = 6;
    localparam int CODE_W  = 32;
    localparam int VBITS_W = 4;
    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(MAX_CODE_BITS + 1);
    localparam int ENTRY_W = LEN_W + CODE_W;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_DATA = 1'b1
    } t_req_type;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SCAN,
        ST_EMIT,
        ST_NEXT,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic             overflow;
        logic [SYM_W-1:0] symbol;
    } t_result;

    // Mask that keeps the low count bits of a pending code.
    function automatic logic [MAX_CODE_BITS-1:0] code_mask(input logic [CNT_W-1:0] count);
        logic [MAX_CODE_BITS-1:0] ones;
        ones = '1;
        return ones >> (CNT_W'(MAX_CODE_BITS) - count);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pfxdec_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the decoder's code table; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pfxdec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/prefix_code_bit_decoder_top.sv
// Top level of the prefix-code bit decoder: request intake, table scan sequencer,
// result holding stage and output register. Depends on pfxdec_pkg and pfxdec_ram.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+-----------------------------------------
//  s        | in        | i_s_tvalid/tready  | tuser kind, tdata table entry or byte,
//           |           |                    | tlast end of stream
//  m        | out       | o_m_tvalid/tready  | tdata symbol and overflow, tlast last
//
// A load request is taken in ST_IDLE. A data byte goes, for each of its bits, through a
// shift, a scan of the code table from the top symbol down that stops at the first hit
// (one table read per cycle) and, on a hit or an overflow, the posting of a result; then
// the byte is closed. The single table read port makes the scan serial.
// Reset marks every table entry unused at once through per-entry used bits.
// A stalled output holds the sequencer only when the held result must move on to the output.
`timescale 1ns / 1ps
`default_nettype none

module prefix_code_bit_decoder_top
    import pfxdec_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // [7:0] entry_symbol, [13:8] entry_length, [45:14] entry_code,
    // [53:46] data_byte, [57:54] valid_bits, [63:58] zero
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // [0] req_type
    input  wire logic                   i_s_tuser,
    input  wire logic                   i_s_tlast,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // [7:0] symbol, [8] overflow, [15:9] zero
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    output logic                        o_m_tlast
);

    // Request fields.
    logic [SYM_W-1:0]     w_entry_symbol;
    logic [LEN_W-1:0]     w_entry_length;
    logic [CODE_W-1:0]    w_entry_code;
    logic [BYTE_BITS-1:0] w_data_byte;
    logic [VBITS_W-1:0]   w_valid_bits;

    assign w_entry_symbol = i_s_tdata[7:0];
    assign w_entry_length = i_s_tdata[13:8];
    assign w_entry_code   = i_s_tdata[45:14];
    assign w_data_byte    = i_s_tdata[53:46];
    assign w_valid_bits   = i_s_tdata[57:54];

    t_state                   r_state, n_state;
    logic [MAX_CODE_BITS-1:0] r_pending, n_pending;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [BYTE_BITS-1:0]     r_byte, n_byte;
    logic [VBITS_W-1:0]       r_bits_left, n_bits_left;
    logic                     r_eos, n_eos;
    logic [ADDR_W-1:0]        r_addr, n_addr;
    logic [ADDR_W-1:0]        r_cmp_addr, n_cmp_addr;
    logic                     r_cmp_vld, n_cmp_vld;
    logic                     r_cmp_used;
    logic [TABLE_DEPTH-1:0]   r_used;
    t_result                  r_res, n_res;
    t_result                  r_hold, n_hold;
    logic                     r_hold_vld, n_hold_vld;
    t_result                  r_out, n_out;
    logic                     r_out_last, n_out_last;
    logic                     r_out_vld, n_out_vld;

    logic                     w_accept;
    logic                     w_load_we;
    logic                     w_can_push;
    logic                     w_hit;
    logic [ENTRY_W-1:0]       w_rd_entry;
    logic [VBITS_W-1:0]       w_nbits;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_load_we  = w_accept && (t_req_type'(i_s_tuser) == REQ_LOAD)
                        && (int'(w_entry_symbol) < SYMBOL_COUNT);
    assign w_can_push = !r_out_vld || i_m_tready;

    pfxdec_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr (w_entry_symbol[ADDR_W-1:0]),
        .i_wdata ({w_entry_length, w_entry_code}),
        .i_raddr (r_addr),
        .o_rdata (w_rd_entry)
    );

    // Compare the entry read last cycle against the pending code.
    always_comb begin
        logic [LEN_W-1:0]         len;
        logic [63:0]              code_wide;
        logic [MAX_CODE_BITS-1:0] code;
        len       = w_rd_entry[ENTRY_W-1 -: LEN_W];
        code_wide = 64'(w_rd_entry[CODE_W-1:0]);
        code      = code_wide[MAX_CODE_BITS-1:0];
        w_hit     = r_cmp_used && (len != '0) && (int'(len) == int'(r_count))
                    && ((code & code_mask(r_count)) == r_pending);
    end

    // A final byte uses only its low valid_bits bits when that count is 1 to 8.
    always_comb begin
        w_nbits = VBITS_W'(BYTE_BITS);
        if (i_s_tlast && (w_valid_bits != '0) && (int'(w_valid_bits) <= BYTE_BITS)) begin
            w_nbits = w_valid_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pending  <= '0;
            r_count    <= '0;
            r_cmp_vld  <= 1'b0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_used     <= '0;
        end else begin
            r_state    <= n_state;
            r_pending  <= n_pending;
            r_count    <= n_count;
            r_cmp_vld  <= n_cmp_vld;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
            if (w_load_we) begin
                r_used[w_entry_symbol[ADDR_W-1:0]] <= 1'b1;
            end
        end
        r_byte      <= n_byte;
        r_bits_left <= n_bits_left;
        r_eos       <= n_eos;
        r_addr      <= n_addr;
        r_cmp_addr  <= n_cmp_addr;
        r_cmp_used  <= r_used[r_addr];
        r_res       <= n_res;
        r_hold      <= n_hold;
        r_out       <= n_out;
        r_out_last  <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_pending   = r_pending;
        n_count     = r_count;
        n_byte      = r_byte;
        n_bits_left = r_bits_left;
        n_eos       = r_eos;
        n_addr      = r_addr;
        n_cmp_addr  = r_cmp_addr;
        n_cmp_vld   = r_cmp_vld;
        n_res       = r_res;
        n_hold      = r_hold;
        n_hold_vld  = r_hold_vld;
        n_out       = r_out;
        n_out_last  = r_out_last;
        n_out_vld   = r_out_vld && !i_m_tready;

        case (r_state)
            ST_IDLE: begin
                if (w_accept && (t_req_type'(i_s_tuser) == REQ_DATA)) begin
                    // Left-align the used bits so each shift takes the top bit.
                    n_byte      = w_data_byte << (VBITS_W'(BYTE_BITS) - w_nbits);
                    n_bits_left = w_nbits;
                    n_eos       = i_s_tlast;
                    n_state     = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                n_pending   = {r_pending[MAX_CODE_BITS-2:0], r_byte[BYTE_BITS-1]};
                n_count     = r_count + 1'b1;
                n_byte      = r_byte << 1;
                n_bits_left = r_bits_left - 1'b1;
                n_addr      = ADDR_W'(SYMBOL_COUNT - 1);
                n_cmp_vld   = 1'b0;
                n_state     = ST_SCAN;
            end
            ST_SCAN: begin
                n_addr     = r_addr - 1'b1;
                n_cmp_addr = r_addr;
                n_cmp_vld  = 1'b1;
                if (r_cmp_vld && w_hit) begin
                    n_res   = '{overflow: 1'b0, symbol: r_cmp_addr};
                    n_state = ST_EMIT;
                end else if (r_cmp_vld && (r_cmp_addr == '0)) begin
                    if (int'(r_count) >= MAX_CODE_BITS) begin
                        n_res   = '{overflow: 1'b1, symbol: '0};
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_NEXT;
                    end
                end
            end
            ST_EMIT: begin
                // The held result is not the last one of this byte; post it.
                if (!r_hold_vld || w_can_push) begin
                    if (r_hold_vld) begin
                        n_out_vld  = 1'b1;
                        n_out      = r_hold;
                        n_out_last = 1'b0;
                    end
                    n_hold     = r_res;
                    n_hold_vld = 1'b1;
                    n_pending  = '0;
                    n_count    = '0;
                    n_state    = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (r_bits_left != '0) begin
                    n_state = ST_SHIFT;
                end else begin
                    if (r_eos) begin
                        n_pending = '0;
                        n_count   = '0;
                    end
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_hold_vld) begin
                    n_state = ST_IDLE;
                end else if (w_can_push) begin
                    n_out_vld  = 1'b1;
                    n_out      = r_hold;
                    n_out_last = 1'b1;
                    n_hold_vld = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OUT_TDATA_W'(r_out);
    assign o_m_tlast  = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= MAX_CODE_BITS)
        else $error("pending code length beyond maximum");

    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_hold_vld)
        else $error("result left behind at end of byte");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && (!r_hold_vld || w_can_push)) |=> (r_count == '0))
        else $error("pending code not cleared after a result");

    a_ovf_zero_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[8]) |-> (o_m_tdata[7:0] == '0))
        else $error("overflow result carries a symbol");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_tready) |=> r_out_vld && $stable(r_out))
        else $error("output result overwritten while stalled");

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for prefix_code_bit_decoder_top: drives code table loads and
// packed data bytes, predicts every decoded symbol and overflow, and checks each result.
// Depends on pfxdec_pkg and the decoder RTL.
`timescale 1ns / 1ps

module testbench;
    import pfxdec_pkg::*;

    localparam int  RANDOM_REQUESTS = 210;
    localparam int  HOLD_OFF_CYCLES = 3000;
    localparam int  PRESSURE_PHASE  = 2;
    // One byte can scan the whole table for each of its bits.
    localparam int  DRAIN_CYCLES    = BYTE_BITS * (SYMBOL_COUNT + 4) + 64;
    localparam time TIMEOUT_NS      = 60_000_000;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             overflow;
        logic             is_last;
    } t_decoded;

    class symbol_tracker;
        logic [LEN_W-1:0]         len_table [TABLE_DEPTH];
        logic [CODE_W-1:0]        code_table [TABLE_DEPTH];
        logic [MAX_CODE_BITS-1:0] pending_bits;
        int unsigned              pending_len;
        t_decoded                 symbols_due [$];
        int                       mismatches;
        int                       symbols_checked;
        int                       overflows_checked;

        function new();
            foreach (len_table[i]) begin
                len_table[i]  = '0;
                code_table[i] = '0;
            end
            pending_bits      = '0;
            pending_len       = 0;
            mismatches        = 0;
            symbols_checked   = 0;
            overflows_checked = 0;
        endfunction

        // Highest symbol whose code equals the pending bits, or -1.
        function int find_hit();
            int          s;
            logic [63:0] mask;
            for (s = TABLE_DEPTH - 1; s >= 0; s--) begin
                if (len_table[s] != 0 && len_table[s] == pending_len) begin
                    mask = (64'd1 << len_table[s]) - 64'd1;
                    if ((code_table[s] & mask[CODE_W-1:0]) ==
                        (pending_bits & mask[MAX_CODE_BITS-1:0]))
                        return s;
                end
            end
            return -1;
        endfunction

        function void note_request(logic kind, logic [IN_TDATA_W-1:0] data, logic eos);
            logic [7:0] sym;
            logic [7:0] dbyte;
            logic [3:0] vb;
            int         nbits;
            int         b;
            int         hit;
            int         n;
            t_decoded   batch [BYTE_BITS];
            if (kind == REQ_LOAD) begin
                sym             = data[7:0];
                len_table[sym]  = data[13:8];
                code_table[sym] = data[45:14];
                return;
            end
            dbyte = data[53:46];
            vb    = data[57:54];
            nbits = BYTE_BITS;
            if (eos && vb >= 1 && vb <= BYTE_BITS)
                nbits = vb;
            n = 0;
            for (b = nbits - 1; b >= 0; b--) begin
                pending_bits = {pending_bits[MAX_CODE_BITS-2:0], dbyte[b]};
                pending_len++;
                hit = find_hit();
                if (hit >= 0) begin
                    batch[n] = '{symbol: hit[7:0], overflow: 1'b0, is_last: 1'b0};
                    n++;
                    pending_bits = '0;
                    pending_len  = 0;
                end else if (pending_len >= MAX_CODE_BITS) begin
                    batch[n] = '{symbol: 8'd0, overflow: 1'b1, is_last: 1'b0};
                    n++;
                    pending_bits = '0;
                    pending_len  = 0;
                end
            end
            if (n > 0)
                batch[n-1].is_last = 1'b1;
            for (b = 0; b < n; b++)
                symbols_due.push_back(batch[b]);
            // The end of a stream drops whatever bits are still pending.
            if (eos) begin
                pending_bits = '0;
                pending_len  = 0;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, logic eos);
            t_decoded want;
            if (symbols_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t ERROR: unexpected result symbol %0d overflow %0b last %0b",
                             $time, data[7:0], data[8], eos);
                return;
            end
            want = symbols_due.pop_front();
            if (want.overflow)
                overflows_checked++;
            else
                symbols_checked++;
            if (data[7:0] !== want.symbol || data[8] !== want.overflow ||
                eos !== want.is_last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t ERROR: expected symbol %0d overflow %0b last %0b, got %0d %0b %0b",
                             $time, want.symbol, want.overflow, want.is_last,
                             data[7:0], data[8], eos);
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   s_tlast;
    logic                   m_tready;
    wire                    s_tready;
    wire                    m_tvalid;
    wire [OUT_TDATA_W-1:0]  m_tdata;
    wire                    m_tlast;

    symbol_tracker board;
    int                    requests_sent;
    int                    data_bytes_sent;
    bit                    gaps_on;
    bit                    hold_off_request;
    bit                    hold_off_done;
    logic [SYM_W-1:0]      live_syms [$];

    prefix_code_bit_decoder_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t timeout with %0d results outstanding", $time, board.symbols_due.size());
        $display("testbench: done, errors");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int draw_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_request(logic [7:0] sym, logic [5:0] len,
            logic [31:0] code, logic [7:0] dbyte, logic [3:0] vb);
        return {6'b0, vb, dbyte, code, len, sym};
    endfunction

    function automatic logic [3:0] final_valid_bits();
        if ($urandom_range(0, 4) != 0)
            return 4'($urandom_range(1, 8));
        return 4'($urandom_range(0, 15));
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(input logic kind, input logic [IN_TDATA_W-1:0] data,
                                input logic eos);
        int gap;
        gap = gaps_on ? draw_gap() : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = data;
        s_tlast  = eos;
        do @(posedge clk); while (s_tready !== 1'b1);
        board.note_request(kind, data, eos);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic load_entry(input logic [7:0] sym, input logic [5:0] len,
                              input logic [31:0] code);
        send_request(REQ_LOAD, pack_request(sym, len, code, 8'($urandom), 4'($urandom)),
                     1'($urandom));
        if (len != 0)
            live_syms.push_back(sym);
    endtask

    task automatic send_byte(input logic [7:0] dbyte, input logic eos, input logic [3:0] vb);
        send_request(REQ_DATA, pack_request(8'($urandom), 6'($urandom), $urandom, dbyte, vb),
                     eos);
        data_bytes_sent++;
    endtask

    task automatic clear_table();
        while (live_syms.size() > 0)
            load_entry(live_syms.pop_front(), 6'd0, $urandom);
    endtask

    // Loads a random complete prefix code so that most bit streams decode.
    task automatic load_prefix_code(input int k, input int maxlen);
        int          leaf_len [16];
        logic [31:0] leaf_bits [16];
        bit          taken [TABLE_DEPTH];
        int          n;
        int          idx;
        int          i;
        logic [7:0]  sym;
        foreach (taken[j])
            taken[j] = 1'b0;
        leaf_len[0]  = 0;
        leaf_bits[0] = '0;
        n = 1;
        while (n < k) begin
            idx = $urandom_range(0, n - 1);
            while (leaf_len[idx] >= maxlen)
                idx = (idx + 1) % n;
            leaf_len[idx]++;
            leaf_bits[idx] = leaf_bits[idx] << 1;
            leaf_len[n]    = leaf_len[idx];
            leaf_bits[n]   = leaf_bits[idx] | 32'd1;
            n++;
        end
        for (i = 0; i < n; i++) begin
            do sym = 8'($urandom); while (taken[sym]);
            taken[sym] = 1'b1;
            // Junk above the code length must not affect matching.
            load_entry(sym, 6'(leaf_len[i]), leaf_bits[i] | ($urandom << leaf_len[i]));
        end
        // A second symbol with the same code: the higher one must win.
        if ($urandom_range(0, 2) == 0) begin
            idx = $urandom_range(0, n - 1);
            load_entry(8'($urandom), 6'(leaf_len[idx]), leaf_bits[idx]);
        end
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left    = 0;
        m_tready      = 1'b0;
        hold_off_done = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_off_request && !hold_off_done) begin
                m_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end else begin
                if (stall_left > 0) begin
                    m_tready = 1'b0;
                    stall_left--;
                end else begin
                    m_tready   = 1'b1;
                    stall_left = gaps_on ? draw_gap() : 0;
                end
                @(posedge clk);
                if (m_tready && m_tvalid === 1'b1)
                    board.check_result(m_tdata, m_tlast);
            end
        end
    end

    initial begin : request_source
        int phase;
        int kind;
        int i;
        int count;
        int len;
        int target;
        logic eos;
        board            = new();
        requests_sent    = 0;
        data_bytes_sent  = 0;
        gaps_on          = 1'b1;
        hold_off_request = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_LOAD;
        s_tlast  = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty table: four bytes run the pending code into overflow.
        send_byte(8'hFF, 1'b0, 4'($urandom));
        send_byte(8'h00, 1'b0, 4'($urandom));
        send_byte(8'hA5, 1'b0, 4'($urandom));
        send_byte(8'h5A, 1'b0, 4'($urandom));
        // One-bit codes give eight results per byte; 255 and 3 share a code.
        load_entry(8'd255, 6'd1, 32'hFFFF_FFFF);
        load_entry(8'd3, 6'd1, 32'h0000_0001);
        load_entry(8'd0, 6'd1, 32'h0000_0000);
        send_byte(8'hFF, 1'b0, 4'd0);
        send_byte(8'h00, 1'b0, 4'd15);
        send_byte(8'h96, 1'b0, 4'd3);
        clear_table();
        // A code longer than the maximum never matches; a full-width one does.
        load_entry(8'd10, 6'd40, 32'hFFFF_FFFF);
        load_entry(8'd200, 6'd32, 32'hDEAD_BEEF);
        send_byte(8'hDE, 1'b0, 4'd8);
        send_byte(8'hAD, 1'b0, 4'd8);
        send_byte(8'hBE, 1'b0, 4'd8);
        send_byte(8'hEF, 1'b0, 4'd8);
        // Final partial bytes, leftover bits and out of range valid bit counts.
        load_entry(8'd1, 6'd3, 32'hFFFF_FFF5);
        send_byte(8'h05, 1'b1, 4'd3);
        send_byte(8'h02, 1'b1, 4'd2);
        send_byte(8'hA0, 1'b1, 4'd0);
        send_byte(8'hB5, 1'b1, 4'd12);

        target = requests_sent + RANDOM_REQUESTS;
        phase  = 0;
        while (requests_sent < target) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            kind    = $urandom_range(0, 9);
            if (phase == PRESSURE_PHASE)
                kind = 0;
            if (kind < 6) begin
                clear_table();
                // Sixteen leaves fit within four bits, enough for up to ten symbols.
                if (phase == PRESSURE_PHASE)
                    load_prefix_code(2, 1);
                else
                    load_prefix_code($urandom_range(2, 10), $urandom_range(4, 8));
                count = (phase == PRESSURE_PHASE) ? 8 : $urandom_range(2, 8);
                if (phase == PRESSURE_PHASE)
                    hold_off_request = 1'b1;
                for (i = 0; i < count; i++) begin
                    eos = (i == count - 1);
                    send_byte(8'($urandom), eos, eos ? final_valid_bits() : 4'($urandom));
                end
            end else if (kind < 8) begin
                // Only long codes: random bytes mostly end in overflow.
                clear_table();
                count = $urandom_range(1, 3);
                for (i = 0; i < count; i++) begin
                    len = $urandom_range(12, 40);
                    load_entry(8'($urandom), 6'(len), $urandom);
                end
                count = $urandom_range(5, 10);
                for (i = 0; i < count; i++) begin
                    eos = (i == count - 1) && ($urandom_range(0, 1) == 1);
                    send_byte(8'($urandom), eos, eos ? final_valid_bits() : 4'($urandom));
                end
            end else begin
                count = $urandom_range(4, 10);
                for (i = 0; i < count; i++) begin
                    if ($urandom_range(0, 1) == 0)
                        load_entry(8'($urandom), 6'($urandom_range(0, 63)), $urandom);
                    else
                        send_byte(8'($urandom), ($urandom_range(0, 9) < 3), 4'($urandom));
                end
            end
            phase++;
        end

        s_tvalid = 1'b0;
        while (board.symbols_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d data bytes) over %0d phases.",
                 requests_sent, data_bytes_sent, phase);
        $display("Checked %0d decoded symbols and %0d overflows, %0d mismatches.",
                 board.symbols_checked, board.overflows_checked, board.mismatches);
        if (board.symbols_due.size() != 0)
            $display("ERROR: %0d results never arrived", board.symbols_due.size());
        if (board.mismatches == 0 && board.symbols_due.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
